FILE: rtl/core/qrpw_pkg.sv
package qrpw_pkg;

  localparam int MAX_VERSION_DEF = 6;

  localparam int COORD_W   = 6;
  localparam int VER_W     = 3;
  localparam int MASK_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_VERSION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd2;

  localparam logic [MASK_W-1:0] MASK_CHECKER  = 3'd0;
  localparam logic [MASK_W-1:0] MASK_ROWS     = 3'd1;
  localparam logic [MASK_W-1:0] MASK_COLS3    = 3'd2;
  localparam logic [MASK_W-1:0] MASK_DIAG3    = 3'd3;
  localparam logic [MASK_W-1:0] MASK_BLOCKS   = 3'd4;
  localparam logic [MASK_W-1:0] MASK_PROD_SUM = 3'd5;
  localparam logic [MASK_W-1:0] MASK_PROD_PAR = 3'd6;
  localparam logic [MASK_W-1:0] MASK_MIXED    = 3'd7;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SEEK = 2'b10
  } state_t;

  typedef logic [COORD_W-1:0] coord_t;

  // residue mod 3 by folding base-4 digits (4 is 1 mod 3)
  function automatic logic [1:0] mod3(input logic [7:0] x);
    logic [3:0] s1;
    logic [2:0] s2;
    s1 = 4'(x[1:0]) + 4'(x[3:2]) + 4'(x[5:4]) + 4'(x[7:6]);
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]);
    if (s2 >= 3'd3) s2 = s2 - 3'd3;
    if (s2 >= 3'd3) s2 = s2 - 3'd3;
    return s2[1:0];
  endfunction

  function automatic logic [VER_W-1:0] eff_version(input logic [VER_W-1:0] v,
                                                   input logic [VER_W-1:0] vmax);
    logic [VER_W-1:0] e;
    e = v;
    if (e == '0) e = VER_W'(1);
    if (e > vmax) e = vmax;
    return e;
  endfunction

  function automatic coord_t side_of(input logic [VER_W-1:0] ev);
    return COORD_W'(17) + {1'b0, ev, 2'b00};
  endfunction

  function automatic logic is_free(input coord_t row, input coord_t col,
                                   input coord_t side, input logic has_align);
    coord_t lo8;
    coord_t alo;
    coord_t ahi;
    logic   f;
    lo8 = side - COORD_W'(8);
    alo = side - COORD_W'(9);
    ahi = side - COORD_W'(5);
    f = 1'b1;
    if (row == COORD_W'(6) || col == COORD_W'(6)) f = 1'b0;
    if (row < COORD_W'(9) && col < COORD_W'(9)) f = 1'b0;
    if (row < COORD_W'(9) && col >= lo8) f = 1'b0;
    if (col < COORD_W'(9) && row >= lo8) f = 1'b0;
    if (has_align && row >= alo && row <= ahi && col >= alo && col <= ahi) f = 1'b0;
    return f;
  endfunction

  function automatic logic mask_hit(input logic [MASK_W-1:0] pat,
                                    input coord_t i, input coord_t j);
    logic [1:0]  i3;
    logic [1:0]  j3;
    logic [1:0]  s3;
    logic [1:0]  p3;
    logic [3:0]  rp;
    logic [6:0]  sum;
    logic [11:0] jq;
    logic        p2;
    logic        hit;
    sum = 7'(i) + 7'(j);
    i3  = mod3({2'b00, i});
    j3  = mod3({2'b00, j});
    s3  = mod3({1'b0, sum});
    rp  = 4'(i3) * 4'(j3);
    p3  = mod3({4'b0000, rp});
    p2  = i[0] & j[0];
    jq  = 12'(j) * 12'd43;       // j/3 for j < 128 is (j*43)>>7
    case (pat)
      MASK_CHECKER:  hit = (sum[0] == 1'b0);
      MASK_ROWS:     hit = (i[0] == 1'b0);
      MASK_COLS3:    hit = (j3 == 2'd0);
      MASK_DIAG3:    hit = (s3 == 2'd0);
      MASK_BLOCKS:   hit = ((i[1] ^ jq[7]) == 1'b0);
      MASK_PROD_SUM: hit = (p2 == 1'b0) && (p3 == 2'd0);
      MASK_PROD_PAR: hit = ((p2 ^ p3[0]) == 1'b0);
      default:       hit = ((sum[0] ^ p3[0]) == 1'b0);
    endcase
    return hit;
  endfunction

endpackage

FILE: rtl/core/qr_module_placement_walker.sv
// An input beat is taken only when idle; the walk then steps over function modules to
// the current free module and on to the next free one, and the result is registered
// on the output, where out_ready can hold it. One beat in flight, the walk checking
// one candidate module per cycle. Input ready only when idle.
// Reset (synchronous, rst_n low): version 1, mask 0, masking on; the walk then
// checks its first module before taking a beat.
module qr_module_placement_walker #(
  parameter int MAX_VERSION = qrpw_pkg::MAX_VERSION_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_start_symbol,
  input  logic                           in_data_bit,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [qrpw_pkg::COORD_W-1:0]   out_module_row,
  output logic [qrpw_pkg::COORD_W-1:0]   out_module_column,
  output logic                           out_module_value,
  output logic                           out_placed,
  output logic                           out_last_module,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [qrpw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qrpw_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import qrpw_pkg::*;

  localparam logic [VER_W-1:0] VMAX = VER_W'(MAX_VERSION);

  state_t state_r, state_nxt;

  logic [VER_W-1:0]  version_r, version_nxt;
  logic [MASK_W-1:0] mask_r, mask_nxt;
  logic              mask_en_r, mask_en_nxt;

  coord_t prc_r, prc_nxt;
  coord_t row_r, row_nxt;
  logic   up_r, up_nxt;
  logic   left_r, left_nxt;
  logic   full_r, full_nxt;

  logic   pend_r, pend_nxt;
  logic   bit_r, bit_nxt;
  logic   res_r, res_nxt;
  coord_t res_row_r, res_row_nxt;
  coord_t res_col_r, res_col_nxt;
  logic   res_val_r, res_val_nxt;

  logic   out_valid_r, out_valid_nxt;
  coord_t out_row_r, out_row_nxt;
  coord_t out_col_r, out_col_nxt;
  logic   out_val_r, out_val_nxt;
  logic   out_placed_r, out_placed_nxt;
  logic   out_last_r, out_last_nxt;

  logic [VER_W-1:0] ver_eff;
  coord_t           side;
  coord_t           cfg_side;
  coord_t           cur_col;
  logic             free_now;
  logic             out_free;
  logic             turn;

  coord_t a_prc;
  coord_t a_row;
  logic   a_up;
  logic   a_left;
  logic   a_full;

  assign ver_eff  = eff_version(version_r, VMAX);
  assign side     = side_of(ver_eff);
  assign cfg_side = side_of(eff_version(cfg_wdata, VMAX));
  assign cur_col  = prc_r - COORD_W'(left_r);
  assign free_now = is_free(row_r, cur_col, side, ver_eff >= VER_W'(2));
  assign out_free = !out_valid_r || out_ready;

  assign in_ready          = (state_r == S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_module_row    = out_row_r;
  assign out_module_column = out_col_r;
  assign out_module_value  = out_val_r;
  assign out_placed        = out_placed_r;
  assign out_last_module   = out_last_r;

  // one zig-zag step
  always_comb begin
    a_prc  = prc_r;
    a_row  = row_r;
    a_up   = up_r;
    a_left = left_r;
    a_full = full_r;
    turn   = up_r ? (row_r == '0) : (row_r >= side - COORD_W'(1));
    if (!left_r) begin
      a_left = 1'b1;
    end else begin
      a_left = 1'b0;
      if (turn) begin
        if (prc_r <= COORD_W'(1)) begin
          a_full = 1'b1;
        end else begin
          a_prc = (prc_r - COORD_W'(2) == COORD_W'(6)) ? COORD_W'(5) : prc_r - COORD_W'(2);
          a_up  = !up_r;
        end
      end else begin
        a_row = up_r ? row_r - COORD_W'(1) : row_r + COORD_W'(1);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    version_nxt    = version_r;
    mask_nxt       = mask_r;
    mask_en_nxt    = mask_en_r;
    prc_nxt        = prc_r;
    row_nxt        = row_r;
    up_nxt         = up_r;
    left_nxt       = left_r;
    full_nxt       = full_r;
    pend_nxt       = pend_r;
    bit_nxt        = bit_r;
    res_nxt        = res_r;
    res_row_nxt    = res_row_r;
    res_col_nxt    = res_col_r;
    res_val_nxt    = res_val_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    out_val_nxt    = out_val_r;
    out_placed_nxt = out_placed_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_start_symbol) begin
            prc_nxt  = side - COORD_W'(1);
            row_nxt  = side - COORD_W'(1);
            up_nxt   = 1'b1;
            left_nxt = 1'b0;
            full_nxt = 1'b0;
          end
          pend_nxt  = 1'b1;
          bit_nxt   = in_data_bit;
          state_nxt = S_SEEK;
        end
      end
      S_SEEK: begin
        if (pend_r) begin
          if (full_r) begin
            if (out_free) begin
              out_valid_nxt  = 1'b1;
              out_row_nxt    = '0;
              out_col_nxt    = '0;
              out_val_nxt    = 1'b0;
              out_placed_nxt = 1'b0;
              out_last_nxt   = 1'b0;
              pend_nxt       = 1'b0;
              state_nxt      = S_IDLE;
            end
          end else begin
            if (free_now) begin
              res_nxt     = 1'b1;
              res_row_nxt = row_r;
              res_col_nxt = cur_col;
              res_val_nxt = bit_r ^ (mask_en_r & mask_hit(mask_r, row_r, cur_col));
              pend_nxt    = 1'b0;
            end
            prc_nxt  = a_prc;
            row_nxt  = a_row;
            up_nxt   = a_up;
            left_nxt = a_left;
            full_nxt = a_full;
          end
        end else if (full_r || free_now) begin
          if (res_r) begin
            if (out_free) begin
              out_valid_nxt  = 1'b1;
              out_row_nxt    = res_row_r;
              out_col_nxt    = res_col_r;
              out_val_nxt    = res_val_r;
              out_placed_nxt = 1'b1;
              out_last_nxt   = full_r;
              res_nxt        = 1'b0;
              state_nxt      = S_IDLE;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          prc_nxt  = a_prc;
          row_nxt  = a_row;
          up_nxt   = a_up;
          left_nxt = a_left;
          full_nxt = a_full;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_VERSION: begin
          version_nxt = cfg_wdata;
          prc_nxt     = cfg_side - COORD_W'(1);
          row_nxt     = cfg_side - COORD_W'(1);
          up_nxt      = 1'b1;
          left_nxt    = 1'b0;
          full_nxt    = 1'b0;
          pend_nxt    = 1'b0;
          res_nxt     = 1'b0;
          state_nxt   = S_SEEK;
        end
        REG_MASK:   mask_nxt    = cfg_wdata;
        REG_ENABLE: mask_en_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SEEK;
      version_r   <= VER_W'(1);
      mask_r      <= MASK_CHECKER;
      mask_en_r   <= 1'b1;
      prc_r       <= COORD_W'(20);
      row_r       <= COORD_W'(20);
      up_r        <= 1'b1;
      left_r      <= 1'b0;
      full_r      <= 1'b0;
      pend_r      <= 1'b0;
      res_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      version_r   <= version_nxt;
      mask_r      <= mask_nxt;
      mask_en_r   <= mask_en_nxt;
      prc_r       <= prc_nxt;
      row_r       <= row_nxt;
      up_r        <= up_nxt;
      left_r      <= left_nxt;
      full_r      <= full_nxt;
      pend_r      <= pend_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_r        <= bit_nxt;
    res_row_r    <= res_row_nxt;
    res_col_r    <= res_col_nxt;
    res_val_r    <= res_val_nxt;
    out_row_r    <= out_row_nxt;
    out_col_r    <= out_col_nxt;
    out_val_r    <= out_val_nxt;
    out_placed_r <= out_placed_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule
